@@ rtl/ils_pkg.sv @@
// Shared constants and types for the indexed list store.
// No dependencies; imported by every module of the block.
package ils_pkg;

    localparam int ILS_CAP   = 64;
    localparam int IDX_W     = $clog2(ILS_CAP);
    localparam int CNT_W     = $clog2(ILS_CAP + 1);
    localparam int DATA_W    = 32;
    localparam int POS_W     = 16;
    localparam int KIND_W    = 3;
    localparam int STAT_W    = 2;
    localparam int AT_W      = POS_W + 1;
    localparam int ILS_GRP   = 8;
    localparam int ILS_NGRP  = (ILS_CAP + ILS_GRP - 1) / ILS_GRP;

    localparam logic [KIND_W-1:0] REQ_READ      = 3'd0;
    localparam logic [KIND_W-1:0] REQ_INS_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] REQ_APPEND    = 3'd2;
    localparam logic [KIND_W-1:0] REQ_INS_AT    = 3'd3;
    localparam logic [KIND_W-1:0] REQ_DELETE    = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  at;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  rd_pos;
    } ils_cell_ctrl_t;

endpackage

@@ rtl/ils_cell.sv @@
// One storage cell of the list: holds one element, shifts with its neighbours.
// Depends on ils_pkg.
module ils_cell (
    input  logic                          aclk,
    input  logic [ils_pkg::IDX_W-1:0]     cell_idx,
    input  ils_pkg::ils_cell_ctrl_t       ctrl,
    input  logic [ils_pkg::DATA_W-1:0]    prev_data,
    input  logic [ils_pkg::DATA_W-1:0]    next_data,
    output logic [ils_pkg::DATA_W-1:0]    data,
    output logic [ils_pkg::DATA_W-1:0]    rd_data
);
    import ils_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            OP_INS: begin
                if (cell_idx == ctrl.at) begin
                    data_next = ctrl.value;
                end else if (cell_idx > ctrl.at) begin
                    data_next = prev_data;
                end
            end
            OP_DEL: begin
                if (cell_idx >= ctrl.at) begin
                    data_next = next_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // only the addressed cell drives the gather tree
    assign rd_data = (cell_idx == ctrl.rd_pos) ? data_reg : '0;

endmodule

@@ rtl/ils_gather.sv @@
// Two-level OR tree (first level registered, final level combinational) that collects the addressed cell's element.
// Depends on ils_pkg.
module ils_gather (
    input  logic                                       aclk,
    input  logic                                       capture,
    input  logic [ils_pkg::ILS_CAP-1:0][ils_pkg::DATA_W-1:0] cell_rd,
    output logic [ils_pkg::DATA_W-1:0]                 rd_data
);
    import ils_pkg::*;

    logic [ILS_NGRP-1:0][DATA_W-1:0] grp_reg;
    logic [ILS_NGRP-1:0][DATA_W-1:0] grp_next;

    always_comb begin
        for (int g = 0; g < ILS_NGRP; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < ILS_GRP; k++) begin
                if (g * ILS_GRP + k < ILS_CAP) begin
                    grp_next[g] = grp_next[g] | cell_rd[g * ILS_GRP + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            grp_reg <= grp_next;
        end
    end

    always_comb begin
        rd_data = '0;
        for (int g = 0; g < ILS_NGRP; g++) begin
            rd_data = rd_data | grp_reg[g];
        end
    end

endmodule

@@ rtl/indexed_list_store_unit.sv @@
// Indexed list store: an ordered list held in a row of shifting cells.
// Depends on ils_pkg, ils_cell and ils_gather.
//
// Input channel s_*: one request per beat (read, insert front, append,
// insert before position, delete at position). Result channel m_*: exactly
// one beat per request, carrying the element read (all ones otherwise), a
// hit flag, a status code and the list length after the request.
// The result passes the request register, the cell update together with the
// first gather level, and the final gather into the output register; a new
// request is taken only when idle, once the last result is in that register.
// Inserts and deletes shift every cell behind the position together, on the same clock edge.
// Reset empties the list at once (length zero); cell contents are not
// cleared, as cells beyond the length are never read.
// A stalled result sits in the output register; the block still takes the
// next request and holds its finished result until the register frees up.
module indexed_list_store_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [ils_pkg::KIND_W-1:0]   s_req_type,
    input  logic signed [ils_pkg::POS_W-1:0]    s_position,
    input  logic signed [ils_pkg::DATA_W-1:0]   s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ils_pkg::DATA_W-1:0]   m_read_value,
    output logic                                m_hit,
    output logic        [ils_pkg::STAT_W-1:0]   m_status,
    output logic        [ils_pkg::CNT_W-1:0]    m_list_length
);
    import ils_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [KIND_W-1:0] kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              hit_reg, hit_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_value_reg;
    logic              m_hit_reg;
    logic [STAT_W-1:0] m_stat_reg;
    logic [CNT_W-1:0]  m_len_reg;

    ils_cell_ctrl_t    cell_ctrl;
    logic [ILS_CAP-1:0][DATA_W-1:0] cell_data;
    logic [ILS_CAP-1:0][DATA_W-1:0] cell_rd;
    logic [DATA_W-1:0] gather_data;

    logic              pos_neg;
    logic [AT_W-1:0]   at_w;
    logic [AT_W-1:0]   count_w;
    logic              out_load;

    assign pos_neg = pos_reg[POS_W-1];
    assign count_w = AT_W'(count_reg);

    // request decode, valid only while in S_EXEC
    always_comb begin
        at_w       = '0;
        hit_next   = 1'b0;
        stat_next  = ST_DONE;
        count_next = count_reg;
        cell_ctrl.op     = OP_NONE;
        cell_ctrl.value  = value_reg;
        cell_ctrl.rd_pos = pos_reg[IDX_W-1:0];
        case (kind_reg)
            REQ_READ: begin
                if (!pos_neg && AT_W'(pos_reg) < count_w) begin
                    hit_next = 1'b1;
                end else begin
                    stat_next = ST_RANGE;
                end
            end
            REQ_INS_FRONT, REQ_APPEND, REQ_INS_AT: begin
                if (kind_reg == REQ_APPEND) begin
                    at_w = count_w;
                end else if (kind_reg == REQ_INS_AT && !pos_neg) begin
                    at_w = AT_W'(pos_reg);
                end
                if (at_w > count_w) begin
                    stat_next = ST_RANGE;
                end else if (count_w >= AT_W'(ILS_CAP)) begin
                    stat_next = ST_FULL;
                end else begin
                    cell_ctrl.op = OP_INS;
                    count_next   = count_reg + 1'b1;
                end
            end
            REQ_DELETE: begin
                if (!pos_neg) begin
                    at_w = AT_W'(pos_reg);
                end
                if (at_w < count_w) begin
                    cell_ctrl.op = OP_DEL;
                    count_next   = count_reg - 1'b1;
                end else begin
                    stat_next = ST_RANGE;
                end
            end
            default: begin
                stat_next = ST_RANGE;
            end
        endcase
        cell_ctrl.at = at_w[IDX_W-1:0];
        if (state_reg != S_EXEC) begin
            cell_ctrl.op = OP_NONE;
            count_next   = count_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < ILS_CAP; g++) begin : g_cell
            logic [DATA_W-1:0] prev_d;
            logic [DATA_W-1:0] next_d;
            if (g == 0) begin : g_first
                assign prev_d = '0;
            end else begin : g_mid_p
                assign prev_d = cell_data[g-1];
            end
            if (g == ILS_CAP - 1) begin : g_last
                assign next_d = '0;
            end else begin : g_mid_n
                assign next_d = cell_data[g+1];
            end
            ils_cell u_cell (
                .aclk      (aclk),
                .cell_idx  (IDX_W'(g)),
                .ctrl      (cell_ctrl),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[g]),
                .rd_data   (cell_rd[g])
            );
        end
    endgenerate

    ils_gather u_gather (
        .aclk    (aclk),
        .capture (state_reg == S_EXEC),
        .cell_rd (cell_rd),
        .rd_data (gather_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_READ) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_READ;
            end
            S_READ: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg  <= s_req_type;
            pos_reg   <= s_position;
            value_reg <= s_value;
        end
        if (state_reg == S_EXEC) begin
            hit_reg  <= hit_next;
            stat_reg <= stat_next;
        end
        if (out_load) begin
            m_value_reg <= hit_reg ? gather_data : '1;
            m_hit_reg   <= hit_reg;
            m_stat_reg  <= stat_reg;
            m_len_reg   <= count_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_value_reg;
    assign m_hit         = m_hit_reg;
    assign m_status      = m_stat_reg;
    assign m_list_length = m_len_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ILS_CAP))
        else $error("element count beyond capacity");

    a_ins_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && cell_ctrl.op == OP_INS)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list");

    a_del_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && cell_ctrl.op == OP_DEL)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not shrink the list");

    a_hit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_hit_reg) |-> m_stat_reg == ST_DONE)
        else $error("hit reported with non-done status");

    a_len_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_len_reg == count_reg)
        else $error("reported length differs from count");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for indexed_list_store_unit: directed table, then random traffic.
// Needs rtl/ils_pkg.sv and the block RTL; results checked against a local predictor or typed rows.
`timescale 1ns / 100ps

module tb;
    import ils_pkg::*;

    localparam logic [KIND_W-1:0] REQ_RSVD_LO = 3'd5;
    localparam logic [KIND_W-1:0] REQ_RSVD_MID = 3'd6;
    localparam logic [KIND_W-1:0] REQ_RSVD_HI = 3'd7;
    localparam logic signed [DATA_W-1:0] MISS_WORD = -32'sd1;
    localparam int RANDOM_REQS = 1250;
    localparam int SEG_LEN = 120;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     hit;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         list_length;
    } list_result_t;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic signed [POS_W-1:0]  pos;
        logic signed [DATA_W-1:0] val;
        bit                       fixed;
        list_result_t             res;
    } req_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [KIND_W-1:0]          s_req_type = '0;
    logic signed [POS_W-1:0]    s_position = '0;
    logic signed [DATA_W-1:0]   s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [DATA_W-1:0]   m_read_value;
    logic                       m_hit;
    logic [STAT_W-1:0]          m_status;
    logic [CNT_W-1:0]           m_list_length;

    // predictor state
    logic signed [DATA_W-1:0]   list_cells [ILS_CAP];
    int                         list_len = 0;

    list_result_t               pending_results [$];
    req_row_t                   directed_rows [$];
    int                         errors = 0;
    int                         n_reqs = 0;
    int                         n_results = 0;
    int                         n_hits = 0;
    int                         n_full = 0;
    int                         n_range = 0;
    int                         peak_len = 0;
    bit                         src_no_gap = 1'b0;
    bit                         snk_no_gap = 1'b0;

    indexed_list_store_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_hit         (m_hit),
        .m_status      (m_status),
        .m_list_length (m_list_length)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Applies one request to the local copy of the list and returns its result.
    function automatic list_result_t apply_request(logic [KIND_W-1:0] kind,
                                                   logic signed [POS_W-1:0] pos,
                                                   logic signed [DATA_W-1:0] val);
        list_result_t r;
        int at;
        r.read_value = MISS_WORD;
        r.hit = 1'b0;
        r.status = ST_DONE;
        case (kind)
            REQ_READ: begin
                if (pos >= 0 && pos < list_len) begin
                    r.read_value = list_cells[pos];
                    r.hit = 1'b1;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            REQ_INS_FRONT, REQ_APPEND, REQ_INS_AT: begin
                if (kind == REQ_INS_FRONT || (kind == REQ_INS_AT && pos < 0))
                    at = 0;
                else if (kind == REQ_APPEND)
                    at = list_len;
                else
                    at = pos;
                // range check wins over the full check
                if (at > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= ILS_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > at; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[at] = val;
                    list_len++;
                end
            end
            REQ_DELETE: begin
                at = (pos < 0) ? 0 : pos;
                if (at < list_len) begin
                    for (int i = at; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.list_length = list_len[CNT_W-1:0];
        return r;
    endfunction

    task automatic add_row(logic [KIND_W-1:0] kind, logic signed [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val, bit fixed,
                           logic signed [DATA_W-1:0] rv, logic hit,
                           logic [STAT_W-1:0] st, logic [CNT_W-1:0] len);
        req_row_t row;
        row.kind = kind;
        row.pos = pos;
        row.val = val;
        row.fixed = fixed;
        row.res = '{read_value: rv, hit: hit, status: st, list_length: len};
        directed_rows.push_back(row);
    endtask

    // Drives one request beat; the expectation is logged once the beat is taken.
    task automatic send_req(logic [KIND_W-1:0] kind, logic signed [POS_W-1:0] pos,
                            logic signed [DATA_W-1:0] val, bit fixed, list_result_t typed);
        int gap;
        list_result_t r;
        gap = src_no_gap ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_position <= pos;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        r = apply_request(kind, pos, val);
        if (fixed)
            r = typed;
        pending_results.push_back(r);
        n_reqs++;
        if (r.hit) n_hits++;
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_RANGE) n_range++;
        if (list_len > peak_len) peak_len = list_len;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 19))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2: v = MISS_WORD;
            3: v = '0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] pick_pos();
        logic signed [POS_W-1:0] p;
        case ($urandom_range(0, 11))
            0: p = $urandom;
            1: p = {1'b1, 15'($urandom)};
            2: p = POS_W'(list_len);
            3: p = POS_W'(list_len + 1);
            4: p = POS_W'($urandom_range(list_len, ILS_CAP + 8));
            default: p = POS_W'($urandom_range(0, (list_len > 0) ? list_len - 1 : 0));
        endcase
        return p;
    endfunction

    // mode 0 fills the list, mode 1 drains it, mode 2 mixes
    function automatic logic [KIND_W-1:0] pick_kind(int mode);
        int r;
        logic [KIND_W-1:0] k;
        r = $urandom_range(0, 99);
        case (mode)
            0: k = (r < 15) ? REQ_READ : (r < 35) ? REQ_INS_FRONT : (r < 60) ? REQ_APPEND :
                   (r < 90) ? REQ_INS_AT : (r < 98) ? REQ_DELETE : 3'($urandom_range(5, 7));
            1: k = (r < 15) ? REQ_READ : (r < 20) ? REQ_INS_FRONT : (r < 25) ? REQ_APPEND :
                   (r < 30) ? REQ_INS_AT : (r < 98) ? REQ_DELETE : 3'($urandom_range(5, 7));
            default: k = (r < 25) ? REQ_READ : (r < 37) ? REQ_INS_FRONT : (r < 49) ? REQ_APPEND :
                   (r < 69) ? REQ_INS_AT : (r < 98) ? REQ_DELETE : 3'($urandom_range(5, 7));
        endcase
        return k;
    endfunction

    // result monitor
    always @(posedge aclk) begin
        list_result_t e;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected (value %h hit %b status %0d len %0d)",
                         $time, m_read_value, m_hit, m_status, m_list_length);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_read_value !== e.read_value) begin
                    $display("%0t: read_value expected %h actual %h", $time, e.read_value,
                             m_read_value);
                    errors++;
                end
                if (m_hit !== e.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, e.hit, m_hit);
                    errors++;
                end
                if (m_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, m_status);
                    errors++;
                end
                if (m_list_length !== e.list_length) begin
                    $display("%0t: list_length expected %0d actual %0d", $time, e.list_length,
                             m_list_length);
                    errors++;
                end
            end
        end
    end

    // result sink with random back-pressure
    initial begin
        int w;
        int taken;
        taken = 0;
        @(posedge aresetn);
        forever begin
            if (taken % 50 == 0)
                snk_no_gap = ($urandom_range(0, 3) == 0);
            w = snk_no_gap ? 0 : $urandom_range(0, 5);
            repeat (w) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        list_result_t none;
        int mode;
        none = '0;
        for (int i = 0; i < ILS_CAP; i++)
            list_cells[i] = '0;

        // kind, position, value, typed?, read_value, hit, status, length
        add_row(REQ_READ,      0,      MISS_WORD,      1, MISS_WORD, 0, ST_RANGE, 0);
        add_row(REQ_DELETE,    -1,     32'sh1234_5678, 1, MISS_WORD, 0, ST_RANGE, 0);
        add_row(REQ_INS_AT,    1,      32'sh0BAD_0BAD, 1, MISS_WORD, 0, ST_RANGE, 0);
        add_row(REQ_RSVD_HI,   0,      32'sh5555_5555, 1, MISS_WORD, 0, ST_RANGE, 0);
        add_row(REQ_APPEND,    0,      32'sh7FFF_FFFF, 1, MISS_WORD, 0, ST_DONE,  1);
        add_row(REQ_INS_FRONT, 16'sh7FFF, 32'sh8000_0000, 1, MISS_WORD, 0, ST_DONE, 2);
        add_row(REQ_INS_AT,    -32768, MISS_WORD,      0, '0, 0, ST_DONE, 0);
        add_row(REQ_INS_AT,    3,      32'sh0,         0, '0, 0, ST_DONE, 0);
        add_row(REQ_READ,      0,      32'sh0,         0, '0, 0, ST_DONE, 0);
        add_row(REQ_READ,      3,      MISS_WORD,      0, '0, 0, ST_DONE, 0);
        add_row(REQ_READ,      4,      32'sh0,         1, MISS_WORD, 0, ST_RANGE, 4);
        add_row(REQ_READ,      32767,  32'shAAAA_AAAA, 1, MISS_WORD, 0, ST_RANGE, 4);
        add_row(REQ_READ,      -1,     32'sh0,         1, MISS_WORD, 0, ST_RANGE, 4);
        add_row(REQ_INS_AT,    2,      32'sd12345,     0, '0, 0, ST_DONE, 0);
        add_row(REQ_DELETE,    32767,  32'sh0,         1, MISS_WORD, 0, ST_RANGE, 5);
        add_row(REQ_DELETE,    -32768, 32'sh0,         0, '0, 0, ST_DONE, 0);
        add_row(REQ_DELETE,    3,      MISS_WORD,      0, '0, 0, ST_DONE, 0);
        add_row(REQ_RSVD_LO,   1,      32'sh1,         1, MISS_WORD, 0, ST_RANGE, 3);
        add_row(REQ_RSVD_MID,  -1,     32'sh1,         1, MISS_WORD, 0, ST_RANGE, 3);
        add_row(REQ_READ,      1,      32'sh0,         0, '0, 0, ST_DONE, 0);
        add_row(REQ_INS_AT,    4,      32'sh1357_9BDF, 1, MISS_WORD, 0, ST_RANGE, 3);
        add_row(REQ_APPEND,    -1,     32'sh5A5A_5A5A, 0, '0, 0, ST_DONE, 0);
        add_row(REQ_READ,      2,      32'sh0,         0, '0, 0, ST_DONE, 0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_req(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].val,
                     directed_rows[i].fixed, directed_rows[i].res);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % SEG_LEN == 0) begin
                src_no_gap = ($urandom_range(0, 3) == 0);
                // fill first so the full case is met early on
                mode = (n / SEG_LEN) % 3;
            end
            send_req(pick_kind(mode), pick_pos(), pick_value(), 0, none);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d requests, %0d result beats; %0d read hits, %0d range rejects,",
                 n_reqs, n_results, n_hits, n_range);
        $display("%0d inserts dropped on a full list, peak length %0d of %0d.",
                 n_full, peak_len, ILS_CAP);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ indexed_list_store_unit.f @@
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/ils_gather.sv
rtl/indexed_list_store_unit.sv
test/tb.sv
